### design/ordered_list_table_macros.svh
// Assertion helpers for the ordered list table
`ifndef ORDERED_LIST_TABLE_MACROS_SVH
`define ORDERED_LIST_TABLE_MACROS_SVH

// same-cycle implication
`define OLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/olt_pkg.sv
`default_nettype none
package olt_pkg;

   localparam logic [3:0] OP_INS_FRONT  = 4'd0;
   localparam logic [3:0] OP_INS_BACK   = 4'd1;
   localparam logic [3:0] OP_INS_AT     = 4'd2;
   localparam logic [3:0] OP_INS_SORTED = 4'd3;
   localparam logic [3:0] OP_READ_AT    = 4'd4;
   localparam logic [3:0] OP_FIND       = 4'd5;
   localparam logic [3:0] OP_REM_FRONT  = 4'd6;
   localparam logic [3:0] OP_REM_AT     = 4'd7;
   localparam logic [3:0] OP_REM_VALUE  = 4'd8;
   localparam logic [3:0] OP_CLEAR      = 4'd9;
   localparam logic [3:0] OP_MAX        = 4'd10;
   localparam logic [3:0] OP_COUNT_GT   = 4'd11;
   localparam logic [3:0] OP_QUERY      = 4'd12;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [31:0] LOW_MARK  = 32'h8000_0000;
   localparam logic [31:0] HIGH_MARK = 32'h7FFF_FFFF;

   typedef struct packed {
      logic load;
      logic setup;
      logic start_loc;
      logic start_shift;
      logic start_scan;
      logic put;
      logic finish;
      logic rd_front;
      logic rd_back;
      logic cap_back;
   } olt_cmd_type;

   typedef struct packed {
      logic       scan_done;
      logic [1:0] status;
      logic [3:0] op;
   } olt_sts_type;

endpackage
`default_nettype wire

### design/olt_ram.sv
`default_nettype none
module olt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### design/olt_ctrl.sv
`default_nettype none
module olt_ctrl
   import olt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire olt_sts_type sts,
   output      olt_cmd_type cmd,
   output      logic        busy,
   output      logic        rsp_strobe
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SETUP = 4'd1;
   localparam logic [3:0] S_LOC   = 4'd2;
   localparam logic [3:0] S_SHIFT = 4'd3;
   localparam logic [3:0] S_PUT   = 4'd4;
   localparam logic [3:0] S_SCAN  = 4'd5;
   localparam logic [3:0] S_FRONT = 4'd6;
   localparam logic [3:0] S_BACK  = 4'd7;
   localparam logic [3:0] S_BCAP  = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            if (sts.status != ST_OK) begin
               state_in = S_FRONT;
            end else if (sts.op == OP_INS_SORTED) begin
               cmd.start_loc = 1'b1;
               state_in      = S_LOC;
            end else if (sts.op inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_AT}) begin
               cmd.start_shift = 1'b1;
               state_in        = S_SHIFT;
            end else if (sts.op inside {[OP_READ_AT:OP_REM_VALUE], OP_MAX, OP_COUNT_GT}) begin
               cmd.start_scan = 1'b1;
               state_in       = S_SCAN;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_FRONT;
            end
         end
         S_LOC: begin
            if (sts.scan_done) begin
               cmd.start_shift = 1'b1;
               state_in        = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (sts.scan_done) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_FRONT;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               cmd.finish = 1'b1;
               state_in   = S_FRONT;
            end
         end
         S_FRONT: begin
            cmd.rd_front = 1'b1;
            state_in     = S_BACK;
         end
         S_BACK: begin
            cmd.rd_back = 1'b1;
            state_in    = S_BCAP;
         end
         S_BCAP: begin
            cmd.cap_back = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule
`default_nettype wire

### design/olt_datapath.sv
`default_nettype none
module olt_datapath
   import olt_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire olt_cmd_type                  cmd,
   output      olt_sts_type                  sts,
   input  wire logic [3:0]                   req_type,
   input  wire logic signed [31:0]           req_item_value,
   input  wire logic [6:0]                   req_item_position,
   output      logic                         ram_we,
   output      logic [$clog2(CAPACITY)-1:0]  ram_waddr,
   output      logic [DATA_WIDTH-1:0]        ram_wdata,
   output      logic [$clog2(CAPACITY)-1:0]  ram_raddr,
   input  wire logic [DATA_WIDTH-1:0]        ram_rdata,
   output      logic [1:0]                   rsp_status,
   output      logic signed [31:0]           rsp_read_value,
   output      logic signed [7:0]            rsp_found_position,
   output      logic [6:0]                   rsp_greater_count,
   output      logic [6:0]                   rsp_list_size,
   output      logic signed [31:0]           rsp_front_value,
   output      logic signed [31:0]           rsp_back_value
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 7) ? CW : 7;
   localparam int DW = DATA_WIDTH;

   logic [3:0]           op_ff, op_in;
   logic signed [DW-1:0] val_ff, val_in;
   logic [6:0]           pos_ff, pos_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [1:0]           status_ff, status_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic                 dir_dn_ff, dir_dn_in;
   logic                 pv_ff, pv_in;
   logic [AW-1:0]        pidx_ff, pidx_in;
   logic                 stop_ff, stop_in;
   logic                 loc_ph_ff, loc_ph_in;
   logic [CW-1:0]        ins_pos_ff, ins_pos_in;
   logic [CW-1:0]        j_ff, j_in;
   logic signed [DW-1:0] rdv_ff, rdv_in;
   logic                 has_rd_ff, has_rd_in;
   logic [7:0]           found_ff, found_in;
   logic [CW-1:0]        gcnt_ff, gcnt_in;
   logic signed [DW-1:0] front_ff, front_in;
   logic signed [DW-1:0] back_ff, back_in;

   logic signed [DW-1:0] rd_s;
   logic [PW-1:0]        pos_w, cnt_w;
   logic [CW-1:0]        pos_c, cnt_m1, ipos;
   logic                 full, empty, issue, elem;
   logic [1:0]           stat_calc;

   assign rd_s   = ram_rdata;
   assign pos_w  = PW'(pos_ff);
   assign cnt_w  = PW'(count_ff);
   assign pos_c  = CW'(pos_w);
   assign cnt_m1 = count_ff - CW'(1);
   assign full   = (count_ff >= CW'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign issue  = (rem_ff != '0) && !stop_ff;
   assign elem   = pv_ff && !stop_ff;

   always_comb begin
      stat_calc = ST_OK;
      case (op_ff)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
            if (full) stat_calc = ST_FULL;
         end
         OP_INS_AT: begin
            if (pos_w > cnt_w) stat_calc = ST_RANGE;
            else if (full) stat_calc = ST_FULL;
         end
         OP_READ_AT: begin
            if (pos_w >= cnt_w) stat_calc = ST_RANGE;
         end
         OP_REM_FRONT, OP_REM_VALUE, OP_MAX: begin
            if (empty) stat_calc = ST_EMPTY;
         end
         OP_REM_AT: begin
            if (empty) stat_calc = ST_EMPTY;
            else if (pos_w >= cnt_w) stat_calc = ST_RANGE;
         end
         default: begin
            stat_calc = ST_OK;
         end
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_INS_FRONT: ipos = '0;
         OP_INS_BACK:  ipos = count_ff;
         OP_INS_AT:    ipos = pos_c;
         default:      ipos = ins_pos_ff;
      endcase
   end

   assign sts.scan_done = stop_ff || ((rem_ff == '0) && !pv_ff);
   assign sts.status    = stat_calc;
   assign sts.op        = op_ff;

   // write port: final insert, or a move/compaction from the scan
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pidx_ff;
      ram_wdata = ram_rdata;
      if (cmd.put) begin
         ram_we    = 1'b1;
         ram_waddr = ins_pos_ff[AW-1:0];
         ram_wdata = val_ff;
      end else if (elem && !loc_ph_ff) begin
         case (op_ff)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT, OP_INS_SORTED: begin
               ram_we    = 1'b1;
               ram_waddr = pidx_ff + AW'(1);
            end
            OP_REM_FRONT, OP_REM_AT: begin
               ram_we    = 1'b1;
               ram_waddr = pidx_ff - AW'(1);
            end
            OP_REM_VALUE: begin
               ram_we    = (rd_s != val_ff);
               ram_waddr = j_ff[AW-1:0];
            end
            default: begin
               ram_we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (cmd.rd_front) ram_raddr = '0;
      else if (cmd.rd_back) ram_raddr = cnt_m1[AW-1:0];
      else ram_raddr = cur_ff[AW-1:0];
   end

   always_comb begin
      op_in      = op_ff;
      val_in     = val_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      cur_in     = cur_ff;
      rem_in     = rem_ff;
      dir_dn_in  = dir_dn_ff;
      pv_in      = issue;
      pidx_in    = cur_ff[AW-1:0];
      stop_in    = stop_ff;
      loc_ph_in  = loc_ph_ff;
      ins_pos_in = ins_pos_ff;
      j_in       = j_ff;
      rdv_in     = rdv_ff;
      has_rd_in  = has_rd_ff;
      found_in   = found_ff;
      gcnt_in    = gcnt_ff;
      front_in   = front_ff;
      back_in    = back_ff;

      // advance the read walk
      if (issue) begin
         cur_in = dir_dn_ff ? (cur_ff - CW'(1)) : (cur_ff + CW'(1));
         rem_in = rem_ff - CW'(1);
      end

      if (elem) begin
         if (loc_ph_ff) begin
            if (rd_s >= val_ff) begin
               ins_pos_in = CW'(pidx_ff);
               stop_in    = 1'b1;
               rem_in     = '0;
            end
         end else begin
            case (op_ff)
               OP_READ_AT: begin
                  rdv_in    = rd_s;
                  has_rd_in = 1'b1;
               end
               OP_FIND: begin
                  if (rd_s == val_ff) begin
                     found_in = 8'(pidx_ff);
                     stop_in  = 1'b1;
                     rem_in   = '0;
                  end
               end
               OP_REM_VALUE: begin
                  if (rd_s != val_ff) j_in = j_ff + CW'(1);
               end
               OP_MAX: begin
                  if (rd_s > rdv_ff) rdv_in = rd_s;
               end
               OP_COUNT_GT: begin
                  if (rd_s > val_ff) gcnt_in = gcnt_ff + CW'(1);
               end
               default: begin
                  j_in = j_ff;
               end
            endcase
         end
      end

      if (cmd.load) begin
         op_in     = req_type;
         val_in    = DW'(req_item_value);
         pos_in    = req_item_position;
         has_rd_in = 1'b0;
         found_in  = 8'hFF;
         gcnt_in   = '0;
         j_in      = '0;
         stop_in   = 1'b0;
         loc_ph_in = 1'b0;
      end

      if (cmd.setup) status_in = stat_calc;

      if (cmd.start_loc) begin
         loc_ph_in  = 1'b1;
         ins_pos_in = count_ff;
         cur_in     = '0;
         rem_in     = count_ff;
         dir_dn_in  = 1'b0;
         pv_in      = 1'b0;
         stop_in    = 1'b0;
      end

      if (cmd.start_shift) begin
         loc_ph_in  = 1'b0;
         ins_pos_in = ipos;
         cur_in     = cnt_m1;
         rem_in     = count_ff - ipos;
         dir_dn_in  = 1'b1;
         pv_in      = 1'b0;
         stop_in    = 1'b0;
      end

      if (cmd.start_scan) begin
         dir_dn_in = 1'b0;
         pv_in     = 1'b0;
         stop_in   = 1'b0;
         cur_in    = '0;
         rem_in    = count_ff;
         case (op_ff)
            OP_READ_AT: begin
               cur_in = pos_c;
               rem_in = CW'(1);
            end
            OP_REM_FRONT: begin
               cur_in = CW'(1);
               rem_in = cnt_m1;
            end
            OP_REM_AT: begin
               cur_in = pos_c + CW'(1);
               rem_in = cnt_m1 - pos_c;
            end
            OP_MAX: begin
               has_rd_in = 1'b1;
               rdv_in    = {1'b1, {(DW-1){1'b0}}};
            end
            default: begin
               cur_in = '0;
            end
         endcase
      end

      if (cmd.put) count_in = count_ff + CW'(1);

      if (cmd.finish) begin
         case (op_ff)
            OP_REM_FRONT, OP_REM_AT: count_in = cnt_m1;
            OP_REM_VALUE:            count_in = j_ff;
            OP_CLEAR:                count_in = '0;
            default:                 count_in = count_ff;
         endcase
      end

      if (cmd.rd_back) front_in = rd_s;
      if (cmd.cap_back) back_in = rd_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rem_ff   <= '0;
         pv_ff    <= 1'b0;
         stop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         rem_ff   <= rem_in;
         pv_ff    <= pv_in;
         stop_ff  <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      status_ff  <= status_in;
      cur_ff     <= cur_in;
      dir_dn_ff  <= dir_dn_in;
      pidx_ff    <= pidx_in;
      loc_ph_ff  <= loc_ph_in;
      ins_pos_ff <= ins_pos_in;
      j_ff       <= j_in;
      rdv_ff     <= rdv_in;
      has_rd_ff  <= has_rd_in;
      found_ff   <= found_in;
      gcnt_ff    <= gcnt_in;
      front_ff   <= front_in;
      back_ff    <= back_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_read_value     = has_rd_ff ? 32'(rdv_ff) : LOW_MARK;
   assign rsp_found_position = found_ff;
   assign rsp_greater_count  = 7'(gcnt_ff);
   assign rsp_list_size      = 7'(count_ff);
   assign rsp_front_value    = empty ? LOW_MARK : 32'(front_ff);
   assign rsp_back_value     = empty ? HIGH_MARK : 32'(back_ff);

endmodule
`default_nettype wire

### design/ordered_list_table.sv
// Clear, query, rejected requests: setup, front read, back read, back capture, result strobe.
// A walk over the entries reads one entry per cycle.
// Sorted insert locates, then shifts; the two walks together cover the whole list.
// Throughput: one request at a time; busy drops in the cycle after the result strobe.
// Reset (synchronous) empties the list; the entry RAM itself is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
`include "ordered_list_table_macros.svh"
module ordered_list_table
   import olt_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [3:0]         req_type,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic [6:0]         req_item_position,
   output      logic               rsp_strobe,
   output      logic [1:0]         rsp_status,
   output      logic signed [31:0] rsp_read_value,
   output      logic signed [7:0]  rsp_found_position,
   output      logic [6:0]         rsp_greater_count,
   output      logic [6:0]         rsp_list_size,
   output      logic signed [31:0] rsp_front_value,
   output      logic signed [31:0] rsp_back_value
);

   localparam int AW = $clog2(CAPACITY);

   olt_cmd_type           cmd;
   olt_sts_type           sts;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

   olt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   olt_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_type           (req_type),
      .req_item_value     (req_item_value),
      .req_item_position  (req_item_position),
      .ram_we             (ram_we),
      .ram_waddr          (ram_waddr),
      .ram_wdata          (ram_wdata),
      .ram_raddr          (ram_raddr),
      .ram_rdata          (ram_rdata),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_greater_count  (rsp_greater_count),
      .rsp_list_size      (rsp_list_size),
      .rsp_front_value    (rsp_front_value),
      .rsp_back_value     (rsp_back_value)
   );

   olt_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   `OLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
   `OLT_ASSERT_NOW(a_strobe_busy, rsp_strobe, busy, "result strobe outside a transaction")
   `OLT_ASSERT_NEXT(a_one_result, rsp_strobe, !rsp_strobe && !busy, "result not single")

endmodule
`default_nettype wire
